FILE: hdl/dtqd_pkg.sv
package dtqd_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int TIME_WIDTH_DEF = 48;

	localparam int FIELD_TIME_W = 48;
	localparam int SIZE_W = 20;
	localparam int SVC_W = 32;
	localparam int CAP_W = 8;
	localparam int COUNT_W = 32;
	localparam int BITS_W = 48;
	localparam int FRAC_W = 16;

	localparam logic [SVC_W-1:0] SVC_RESET = 32'h0001_0000;
	localparam logic [CAP_W-1:0] CAP_RESET = 8'h00;

	localparam logic REG_SERVICE_TIME = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	typedef struct packed {
		logic [FIELD_TIME_W-1:0] arrival_time;
		logic [SIZE_W-1:0] size_bits;
	} packet_t;

	typedef struct packed {
		logic accepted;
		logic [FIELD_TIME_W-1:0] departure_time;
		logic [CAP_W-1:0] occupancy;
		logic [COUNT_W-1:0] arrivals_total;
		logic [COUNT_W-1:0] drops_total;
		logic [BITS_W-1:0] bits_total;
	} result_t;

endpackage

FILE: hdl/dtqd_ram.sv
module dtqd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/drop_tail_queue_departure_model_unit.sv
// Drop-tail packet queue that computes departure times by the Lindley recursion.
// A packet word is taken at a rising edge where start is high and busy is low.
// Exactly one result word follows per packet; it is shown for a single cycle
// with done high, and the receiver cannot stall it.
// After acceptance a packet passes the multiply state; then, unless unlimited
// mode or an empty queue skips them, a compare state and a read state for each
// held departure retired, and a final compare when a held departure remains;
// then the placement state, from which the result word is registered.
// Busy drops in the done cycle, so a new packet can be accepted at the end of it.
// Each retirement takes a compare state and a read state because the held
// departures live in a RAM with one registered read port, and one shared
// comparator serves both the retire test and the max rule.
// The service time multiply has a state of its own.
// The APB port holds the service time per bit (16.16 ticks) at address 0 and
// the queue capacity at address 4; write them only while the block is idle.
// Reset at once clears queue, last departure and counters, resets the registers;
// the departure RAM needs no clearing since only written entries are ever read.
module drop_tail_queue_departure_model_unit #(
	parameter int QUEUE_DEPTH = dtqd_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_WIDTH = dtqd_pkg::TIME_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dtqd_pkg::packet_t packet,
	output logic done,
	output dtqd_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	import dtqd_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int PROD_W = SIZE_W + SVC_W;
	localparam int SVC_T_W = PROD_W - FRAC_W;
	localparam int SUM_W = ((TIME_WIDTH > SVC_T_W) ? TIME_WIDTH : SVC_T_W) + 1;
	localparam logic [TIME_WIDTH-1:0] TIME_MASK = '1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_CMP  = 5'b00100,
		S_READ = 5'b01000,
		S_CALC = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [SVC_W-1:0] svc_q;
	logic [CAP_W-1:0] cap_q;
	logic cfg_wr;

	logic [TIME_WIDTH-1:0] arr_q;
	logic [SIZE_W-1:0] size_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TIME_WIDTH-1:0] last_q;
	logic [COUNT_W-1:0] arrivals_q;
	logic [COUNT_W-1:0] drops_q;
	logic [BITS_W-1:0] bits_q;
	logic done_q;
	result_t result_q;

	logic [TIME_WIDTH-1:0] ring_rdata;
	logic ring_we;
	logic [IDX_W-1:0] tail;
	logic [CNT_W:0] tail_wide;

	logic [TIME_WIDTH-1:0] cmp_a, cmp_b;
	logic lt;
	logic pop;
	logic unlimited;
	logic [CW-1:0] cap_eff;
	logic room;
	logic [TIME_WIDTH-1:0] base;
	logic [SUM_W-1:0] sum;
	logic [TIME_WIDTH-1:0] dep;
	logic [CNT_W-1:0] cnt_after;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svc_q <= SVC_RESET;
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SERVICE_TIME: svc_q <= pwdata;
				REG_CAPACITY: cap_q <= pwdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SERVICE_TIME: prdata = svc_q;
			REG_CAPACITY: prdata = 32'(cap_q);
			default: prdata = '0;
		endcase
	end

	dtqd_ram #(
		.WIDTH(TIME_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk(clk),
		.we(ring_we),
		.waddr(tail),
		.wdata(dep),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	// The one comparator tests the ring front while retiring and picks the
	// later of arrival and last departure when the packet is placed.
	assign cmp_a = (state_q == S_CMP) ? ring_rdata : last_q;
	assign cmp_b = arr_q;
	assign lt = cmp_a < cmp_b;

	assign unlimited = (cap_q == '0);
	assign pop = (state_q == S_CMP) && lt;
	assign cap_eff = (CW'(cap_q) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_q);
	assign room = CW'(cnt_q) < cap_eff;

	assign base = lt ? arr_q : last_q;
	assign sum = SUM_W'(base) + SUM_W'(prod_q[PROD_W-1:FRAC_W]);
	assign dep = (sum > SUM_W'(TIME_MASK)) ? TIME_MASK : sum[TIME_WIDTH-1:0];

	assign tail_wide = (CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q);
	assign tail = (tail_wide >= (CNT_W+1)'(QUEUE_DEPTH)) ?
		IDX_W'(tail_wide - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_wide);

	assign ring_we = (state_q == S_CALC) && !unlimited && room;
	assign cnt_after = ring_we ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = (unlimited || cnt_q == '0) ? S_CALC : S_CMP;
			end
			S_CMP: begin
				state_d = lt ? S_READ : S_CALC;
			end
			S_READ: begin
				state_d = (cnt_q == '0) ? S_CALC : S_CMP;
			end
			S_CALC: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			cnt_q <= '0;
			last_q <= '0;
			arrivals_q <= '0;
			drops_q <= '0;
			bits_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_CALC);
			if (pop) begin
				head_q <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == S_CALC) begin
				arrivals_q <= arrivals_q + 1'b1;
				bits_q <= bits_q + BITS_W'(size_q);
				if (unlimited || room) begin
					last_q <= dep;
				end else begin
					drops_q <= drops_q + 1'b1;
				end
				cnt_q <= cnt_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			arr_q <= TIME_WIDTH'(packet.arrival_time);
			size_q <= packet.size_bits;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(size_q) * PROD_W'(svc_q);
		end
		if (state_q == S_CALC) begin
			result_q.accepted <= unlimited || room;
			result_q.departure_time <= (unlimited || room) ? FIELD_TIME_W'(dep) : '0;
			result_q.occupancy <= unlimited ? '0 : CAP_W'(cnt_after);
			result_q.arrivals_total <= arrivals_q + 1'b1;
			result_q.drops_total <= (unlimited || room) ? drops_q : drops_q + 1'b1;
			result_q.bits_total <= bits_q + BITS_W'(size_q);
		end
	end

	assign done = done_q;
	assign result = result_q;

	a_done_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_CALC))
		else $error("result strobe without a placement cycle");

	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted packet did not make the block busy");

	a_drop_zero_departure: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.accepted |-> result_q.departure_time == '0)
		else $error("dropped packet reports a departure time");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("retirement did not lower the held count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> CW'(cnt_q) < CW'(QUEUE_DEPTH))
		else $error("write into a full departure ring");

endmodule

FILE: verif/tb_drop_tail_queue_departure_model_unit.sv
`timescale 1ns / 1ps

module tb_drop_tail_queue_departure_model_unit;
	import dtqd_pkg::*;

	localparam logic [63:0] TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;
	localparam int QUIET_LIMIT = 2000;

	typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic reg_idx;
		logic [31:0] value;
		packet_t pkt;
		logic typed;
		result_t want;
	} step_row_t;

	typedef struct packed {
		logic [31:0] svc;
		logic [7:0] cap;
		logic [19:0] size_max;
		logic [7:0] pace;
	} load_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	packet_t packet = '0;
	logic done;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [47:0] held_departure [QUEUE_DEPTH_DEF];
	int held_head = 0;
	int held_count = 0;
	logic [47:0] latest_departure = '0;
	logic [31:0] seen_arrivals = '0;
	logic [31:0] seen_drops = '0;
	logic [47:0] seen_bits = '0;
	logic [31:0] svc_per_bit = SVC_RESET;
	logic [7:0] capacity = CAP_RESET;

	result_t awaited_reports [$];
	int errors = 0;
	int packets_sent = 0;
	int register_writes = 0;
	int peak_occupancy = 0;
	int gap_max = 8;
	int quiet_cycles = 0;

	step_row_t head_rows [22] = '{
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd100, 20'd1000}, 1'b1,
			'{1'b1, 48'd1100, 8'd0, 32'd1, 32'd0, 48'd1000}},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd0, 20'd0}, 1'b1,
			'{1'b1, 48'd1100, 8'd0, 32'd2, 32'd0, 48'd1000}},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd2000, 20'hFFFFF}, 1'b1,
			'{1'b1, 48'd1050575, 8'd0, 32'd3, 32'd0, 48'd1049575}},
		'{ROW_WRITE, REG_SERVICE_TIME, 32'd0, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd10, 20'hFFFFF}, 1'b1,
			'{1'b1, 48'd1050575, 8'd0, 32'd4, 32'd0, 48'd2098150}},
		'{ROW_WRITE, REG_SERVICE_TIME, 32'd65536, '0, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd1, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050575, 20'd10}, 1'b1,
			'{1'b1, 48'd1050585, 8'd1, 32'd5, 32'd0, 48'd2098160}},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050585, 20'd10}, 1'b1,
			'{1'b0, 48'd0, 8'd1, 32'd6, 32'd1, 48'd2098170}},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050586, 20'd5}, 1'b1,
			'{1'b1, 48'd1050591, 8'd1, 32'd7, 32'd1, 48'd2098175}},
		'{ROW_WRITE, REG_CAPACITY, 32'd4, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050591, 20'd100}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050591, 20'd100}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050591, 20'd100}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050591, 20'd0}, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd2, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050692, 20'd1}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1050792, 20'd1}, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd255, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1060000, 20'd7}, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd0, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd1060000, 20'd3}, 1'b0, '0}
	};

	// Saturated departures pin the last departure at the top of the time range,
	// so these rows can only run once everything else is done.
	step_row_t tail_rows [7] = '{
		'{ROW_WRITE, REG_SERVICE_TIME, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd0, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'hFFFF_FFFF_FFFF, 20'hFFFFF}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'd0, 20'd1}, 1'b0, '0},
		'{ROW_WRITE, REG_CAPACITY, 32'd3, '0, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'hFFFF_FFFF_FFFF, 20'd0}, 1'b0, '0},
		'{ROW_PACKET, REG_SERVICE_TIME, 32'd0, '{48'hFFFF_FFFF_FFFF, 20'd5}, 1'b0, '0}
	};

	load_phase_t load_phases [9] = '{
		'{32'd65536, 8'd0, 20'd4095, 8'd100},
		'{32'd0, 8'd3, 20'hFFFFF, 8'd100},
		'{32'd32768, 8'd1, 20'd1000, 8'd120},
		'{32'd327803, 8'd8, 20'd300, 8'd90},
		'{32'hFFFF_FFFF, 8'd16, 20'd64, 8'd100},
		'{32'd98304, 8'd128, 20'd2000, 8'd30},
		'{32'd65536, 8'd0, 20'd2000, 8'd50},
		'{32'd65536, 8'd255, 20'd500, 8'd30},
		'{32'd1, 8'd5, 20'hFFFFF, 8'd100}
	};

	drop_tail_queue_departure_model_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.packet(packet),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic result_t lindley_step(packet_t p);
		result_t r;
		logic [63:0] base;
		logic [63:0] service;
		logic [63:0] dep;
		int limit;
		r = '0;
		seen_arrivals = seen_arrivals + 1;
		seen_bits = seen_bits + 48'(p.size_bits);
		base = (64'(p.arrival_time) > 64'(latest_departure)) ? 64'(p.arrival_time)
			: 64'(latest_departure);
		service = (64'(p.size_bits) * 64'(svc_per_bit)) >> FRAC_W;
		dep = (service > TIME_MAX - base) ? TIME_MAX : base + service;
		limit = (int'(capacity) > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : int'(capacity);
		if (capacity != 0) begin
			while (held_count > 0 && held_departure[held_head] < p.arrival_time) begin
				held_head = (held_head + 1) % QUEUE_DEPTH_DEF;
				held_count--;
			end
		end
		if (capacity == 0 || held_count < limit) begin
			latest_departure = dep[47:0];
			r.accepted = 1'b1;
			r.departure_time = dep[47:0];
			if (capacity != 0) begin
				held_departure[(held_head + held_count) % QUEUE_DEPTH_DEF] = dep[47:0];
				held_count++;
			end
		end else begin
			seen_drops = seen_drops + 1;
		end
		if (capacity != 0) begin
			r.occupancy = 8'(held_count);
		end
		if (held_count > peak_occupancy && capacity != 0) begin
			peak_occupancy = held_count;
		end
		r.arrivals_total = seen_arrivals;
		r.drops_total = seen_drops;
		r.bits_total = seen_bits;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] readback_want;
		start <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		apb_access(1'b1, {idx, 2'b00}, value, rd);
		if (idx == REG_SERVICE_TIME) begin
			svc_per_bit = value;
		end else begin
			capacity = value[7:0];
		end
		readback_want = (idx == REG_SERVICE_TIME) ? svc_per_bit : 32'(capacity);
		apb_access(1'b0, {idx, 2'b00}, 32'd0, rd);
		check_field("register readback", 64'(readback_want), 64'(rd));
		register_writes++;
	endtask

	task automatic send_packet(input packet_t p, input logic typed, input result_t want);
		int gap;
		result_t r;
		gap = $urandom_range(gap_max, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		packet <= p;
		do @(posedge clk); while (busy);
		r = lindley_step(p);
		awaited_reports = {awaited_reports, (typed ? want : r)};
		packets_sent++;
	endtask

	task automatic run_row(input step_row_t row);
		if (row.kind == ROW_WRITE) begin
			set_register(row.reg_idx, row.value);
		end else begin
			send_packet(row.pkt, row.typed, row.want);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (awaited_reports.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: %p", $time, result);
			end else begin
				want = awaited_reports.pop_front();
				check_field("accepted", 64'(want.accepted), 64'(result.accepted));
				check_field("departure_time", 64'(want.departure_time),
					64'(result.departure_time));
				check_field("occupancy", 64'(want.occupancy), 64'(result.occupancy));
				check_field("arrivals_total", 64'(want.arrivals_total),
					64'(result.arrivals_total));
				check_field("drops_total", 64'(want.drops_total), 64'(result.drops_total));
				check_field("bits_total", 64'(want.bits_total), 64'(result.bits_total));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("tb_drop_tail_queue_departure_model_unit: errors");
			$finish;
		end
	end

	initial begin
		packet_t p;
		logic [47:0] cur;
		logic [63:0] mean_svc;
		logic [63:0] inc_max;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (head_rows[i]) begin
			run_row(head_rows[i]);
		end

		foreach (load_phases[ph]) begin
			set_register(REG_SERVICE_TIME, load_phases[ph].svc);
			set_register(REG_CAPACITY, 32'(load_phases[ph].cap));
			gap_max = (ph % 3 == 1) ? 0 : 8;
			mean_svc = ((64'(load_phases[ph].size_max) >> 1) * 64'(load_phases[ph].svc))
				>> FRAC_W;
			inc_max = mean_svc * 2 * 64'(load_phases[ph].pace) / 100;
			if (inc_max < 20) begin
				inc_max = 20;
			end
			cur = latest_departure + 48'($urandom_range(1000, 0));
			for (int k = 0; k < 180; k++) begin
				case ($urandom_range(15, 0))
					0: p.size_bits = '0;
					1: p.size_bits = load_phases[ph].size_max;
					default: p.size_bits = 20'($urandom_range(32'(load_phases[ph].size_max), 0));
				endcase
				if ($urandom_range(19, 0) == 0) begin
					p.arrival_time = cur - 48'($urandom_range(1000, 0));
				end else begin
					cur = cur + 48'($urandom_range(inc_max[31:0], 0));
					p.arrival_time = cur;
				end
				send_packet(p, 1'b0, '0);
			end
		end

		gap_max = 8;
		foreach (tail_rows[i]) begin
			run_row(tail_rows[i]);
		end

		start <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d packets, %0d of them dropped, peak occupancy %0d.",
			packets_sent, seen_drops, peak_occupancy);
		$display("Made %0d register writes across %0d load phases and saturated departures.",
			register_writes, $size(load_phases));
		if (errors == 0 && awaited_reports.size() == 0) begin
			$display("tb_drop_tail_queue_departure_model_unit: clean");
		end else begin
			$display("tb_drop_tail_queue_departure_model_unit: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/dtqd_pkg.sv
hdl/dtqd_ram.sv
hdl/drop_tail_queue_departure_model_unit.sv
verif/tb_drop_tail_queue_departure_model_unit.sv
